// ===== design/csdp_pkg.sv =====
package csdp_pkg;

    localparam logic [29:0] PLL_HZ     = 30'd900000000;
    localparam logic [19:0] FRAC_DEN   = 20'd1000000;
    localparam logic [31:0] FREQ_RESET = 32'd28074000;

    localparam logic [17:0] P1_OFFSET  = 18'd512;
    localparam logic [17:0] PLL_P1     = 18'(128 * 36 - 512);
    localparam logic [19:0] PLL_P2     = 20'd0;
    localparam logic [19:0] PLL_P3     = 20'd1;

    localparam logic [7:0] PLL_BASE     = 8'd26;
    localparam logic [7:0] DIV_BASE     = 8'd42;
    localparam logic [7:0] REG_OE       = 8'd3;
    localparam logic [7:0] OE_ON        = 8'hFE;
    localparam logic [7:0] OE_OFF       = 8'hFF;
    localparam logic [7:0] REG_MS_CTRL  = 8'd16;
    localparam logic [7:0] MS_CTRL_VAL  = 8'h0F;
    localparam logic [7:0] REG_PLL_RST  = 8'd177;
    localparam logic [7:0] PLL_RST_VAL  = 8'h20;

    localparam logic [4:0] DIV_A_ITER = 5'd30;
    localparam logic [4:0] DIV_B_ITER = 5'd20;
    localparam logic [4:0] DIV_C_ITER = 5'd7;

    typedef enum logic [1:0] {
        CMD_INIT     = 2'd0,
        CMD_SET_FREQ = 2'd1,
        CMD_SET_OE   = 2'd2
    } t_command;

    typedef enum logic [2:0] {
        SEL_STATUS,
        SEL_OE_OFF,
        SEL_OE_STATE,
        SEL_PLL,
        SEL_DIV,
        SEL_MS_CTRL,
        SEL_PLL_RST
    } t_sel;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD_A,
        OP_STEP_F,
        OP_MUL,
        OP_LOAD_B,
        OP_LOAD_C,
        OP_STEP_K,
        OP_PACK
    } t_dp_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_A,
        S_MUL,
        S_LOAD_B,
        S_DIV_B,
        S_LOAD_C,
        S_DIV_C,
        S_PACK,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_dp_op     op;
        logic       store_freq;
        logic       store_oe;
        logic       emit;
        t_sel       sel;
        logic [2:0] idx;
        logic       err;
        logic       last;
    } t_dp_cmd;

    typedef struct packed {
        logic slot_free;
        logic freq_zero;
        logic oe;
    } t_dp_stat;

    function automatic logic [7:0] f_param_byte(input logic [2:0]  idx,
                                                input logic [17:0] p1,
                                                input logic [19:0] p2,
                                                input logic [19:0] p3);
        logic [7:0] b;
        case (idx)
            3'd0:    b = p3[15:8];
            3'd1:    b = p3[7:0];
            3'd2:    b = {6'b0, p1[17:16]};
            3'd3:    b = p1[15:8];
            3'd4:    b = p1[7:0];
            3'd5:    b = {p3[19:16], p2[19:16]};
            3'd6:    b = p2[15:8];
            default: b = p2[7:0];
        endcase
        return b;
    endfunction

endpackage

// ===== design/csdp_datapath.sv =====
module csdp_datapath import csdp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [31:0] i_frequency_hz,
    input  logic        i_enable,
    output t_dp_stat    o_stat,
    input  logic        i_ready,
    output logic        o_valid,
    output logic [7:0]  o_reg_address,
    output logic [7:0]  o_reg_data,
    output logic        o_is_write,
    output logic        o_error,
    output logic        o_last
);

    logic [31:0] r_freq;
    logic        r_oe;
    logic [31:0] r_rem;
    logic [29:0] r_quo;
    logic [51:0] r_prod;
    logic [10:0] r_a;
    logic [17:0] r_p1;
    logic [19:0] r_p2;

    logic        r_ovalid;
    logic [7:0]  r_addr;
    logic [7:0]  r_data;
    logic        r_wr;
    logic        r_err;
    logic        r_last;

    logic [31:0] divisor;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        qbit;
    logic        slot_free;
    logic [7:0]  n_addr;
    logic [7:0]  n_data;
    logic        n_wr;

    assign divisor   = (i_cmd.op == OP_STEP_K) ? {12'b0, FRAC_DEN} : r_freq;
    assign trial     = {r_rem, r_quo[29]};
    assign diff      = trial - {1'b0, divisor};
    assign qbit      = ~diff[32];
    assign slot_free = ~r_ovalid | i_ready;

    assign o_stat = {slot_free, (r_freq == 32'd0), r_oe};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= FREQ_RESET;
            r_oe   <= 1'b0;
        end else begin
            if (i_cmd.store_freq) begin
                r_freq <= i_frequency_hz;
            end
            if (i_cmd.store_oe) begin
                r_oe <= i_enable;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD_A: begin
                r_rem <= 32'd0;
                r_quo <= PLL_HZ;
            end
            OP_STEP_F, OP_STEP_K: begin
                r_rem <= qbit ? diff[31:0] : trial[31:0];
                r_quo <= {r_quo[28:0], qbit};
            end
            OP_MUL: begin
                r_prod <= {20'b0, r_rem} * {32'b0, FRAC_DEN};
                r_a    <= r_quo[10:0];
            end
            OP_LOAD_B: begin
                r_rem <= r_prod[51:20];
                r_quo <= {r_prod[19:0], 10'b0};
            end
            OP_LOAD_C: begin
                r_rem <= {12'b0, r_quo[19:0]};
                r_quo <= 30'd0;
            end
            OP_PACK: begin
                r_p1 <= {r_a, r_quo[6:0]} - P1_OFFSET;
                r_p2 <= r_rem[19:0];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_addr = 8'd0;
        n_data = 8'd0;
        n_wr   = 1'b1;
        case (i_cmd.sel)
            SEL_OE_OFF: begin
                n_addr = REG_OE;
                n_data = OE_OFF;
            end
            SEL_OE_STATE: begin
                n_addr = REG_OE;
                n_data = r_oe ? OE_ON : OE_OFF;
            end
            SEL_PLL: begin
                n_addr = PLL_BASE + {5'b0, i_cmd.idx};
                n_data = f_param_byte(i_cmd.idx, PLL_P1, PLL_P2, PLL_P3);
            end
            SEL_DIV: begin
                n_addr = DIV_BASE + {5'b0, i_cmd.idx};
                n_data = f_param_byte(i_cmd.idx, r_p1, r_p2, FRAC_DEN);
            end
            SEL_MS_CTRL: begin
                n_addr = REG_MS_CTRL;
                n_data = MS_CTRL_VAL;
            end
            SEL_PLL_RST: begin
                n_addr = REG_PLL_RST;
                n_data = PLL_RST_VAL;
            end
            default: begin
                n_wr = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_addr <= n_addr;
            r_data <= n_data;
            r_wr   <= n_wr;
            r_err  <= i_cmd.err;
            r_last <= i_cmd.last;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_reg_address = r_addr;
    assign o_reg_data    = r_data;
    assign o_is_write    = r_wr;
    assign o_error       = r_err;
    assign o_last        = r_last;

endmodule

// ===== design/csdp_controller.sv =====
module csdp_controller import csdp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_frequency_hz,
    input  logic        i_present,
    input  t_dp_stat    i_stat,
    output t_dp_cmd     o_cmd
);

    localparam logic [4:0] STEP_OE_OFF  = 5'd0;
    localparam logic [4:0] STEP_PLL     = 5'd1;
    localparam logic [4:0] STEP_PLL_END = 5'd8;
    localparam logic [4:0] STEP_DIV     = 5'd9;
    localparam logic [4:0] STEP_DIV_END = 5'd16;
    localparam logic [4:0] STEP_MS_CTRL = 5'd17;
    localparam logic [4:0] STEP_PLL_RST = 5'd18;
    localparam logic [4:0] STEP_OE      = 5'd19;
    localparam logic [4:0] STEP_STATUS  = 5'd20;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [4:0] r_step, n_step;
    logic       r_err, n_err;
    logic       r_init, n_init;

    t_sel       sel;
    logic [2:0] idx;
    logic [4:0] step_next;
    logic       done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 5'd0;
            r_step  <= STEP_STATUS;
            r_err   <= 1'b0;
            r_init  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_step  <= n_step;
            r_err   <= n_err;
            r_init  <= n_init;
        end
    end

    // decode the emission step
    always_comb begin
        sel       = SEL_STATUS;
        idx       = 3'd0;
        step_next = r_step + 5'd1;
        done      = 1'b0;
        case (r_step) inside
            STEP_OE_OFF: begin
                sel = SEL_OE_OFF;
            end
            [STEP_PLL:STEP_PLL_END]: begin
                sel = SEL_PLL;
                idx = 3'(r_step - STEP_PLL);
                if (r_step == STEP_PLL_END && i_stat.freq_zero) begin
                    step_next = STEP_OE;
                    done      = ~i_stat.oe;
                end
            end
            [STEP_DIV:STEP_DIV_END]: begin
                sel = SEL_DIV;
                idx = 3'(r_step - STEP_DIV);
            end
            STEP_MS_CTRL: begin
                sel = SEL_MS_CTRL;
            end
            STEP_PLL_RST: begin
                sel  = SEL_PLL_RST;
                done = ~(r_init & i_stat.oe);
            end
            STEP_OE: begin
                sel  = SEL_OE_STATE;
                done = 1'b1;
            end
            default: begin
                sel  = SEL_STATUS;
                done = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_step  = r_step;
        n_err   = r_err;
        n_init  = r_init;
        o_cmd   = '0;
        o_cmd.op  = OP_NONE;
        o_cmd.sel = sel;
        o_cmd.idx = idx;
        o_cmd.err = r_err;
        o_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_command)
                        CMD_INIT: begin
                            n_init = 1'b1;
                            n_err  = 1'b0;
                            if (!i_present) begin
                                n_step  = STEP_STATUS;
                                n_state = S_EMIT;
                            end else if (i_stat.freq_zero) begin
                                n_err   = 1'b1;
                                n_step  = STEP_OE_OFF;
                                n_state = S_EMIT;
                            end else begin
                                n_step   = STEP_OE_OFF;
                                n_cnt    = DIV_A_ITER - 5'd1;
                                o_cmd.op = OP_LOAD_A;
                                n_state  = S_DIV_A;
                            end
                        end
                        CMD_SET_FREQ: begin
                            o_cmd.store_freq = 1'b1;
                            n_init = 1'b0;
                            n_err  = 1'b0;
                            if (i_frequency_hz == 32'd0) begin
                                n_err   = 1'b1;
                                n_step  = STEP_STATUS;
                                n_state = S_EMIT;
                            end else if (!i_present) begin
                                n_step  = STEP_STATUS;
                                n_state = S_EMIT;
                            end else begin
                                n_step   = STEP_DIV;
                                n_cnt    = DIV_A_ITER - 5'd1;
                                o_cmd.op = OP_LOAD_A;
                                n_state  = S_DIV_A;
                            end
                        end
                        CMD_SET_OE: begin
                            o_cmd.store_oe = 1'b1;
                            n_init  = 1'b0;
                            n_err   = 1'b0;
                            n_step  = i_present ? STEP_OE : STEP_STATUS;
                            n_state = S_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV_A: begin
                o_cmd.op = OP_STEP_F;
                n_cnt    = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_LOAD_B;
            end
            S_LOAD_B: begin
                o_cmd.op = OP_LOAD_B;
                n_cnt    = DIV_B_ITER - 5'd1;
                n_state  = S_DIV_B;
            end
            S_DIV_B: begin
                o_cmd.op = OP_STEP_F;
                n_cnt    = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_state = S_LOAD_C;
                end
            end
            S_LOAD_C: begin
                o_cmd.op = OP_LOAD_C;
                n_cnt    = DIV_C_ITER - 5'd1;
                n_state  = S_DIV_C;
            end
            S_DIV_C: begin
                o_cmd.op = OP_STEP_K;
                n_cnt    = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_state = S_PACK;
                end
            end
            S_PACK: begin
                o_cmd.op = OP_PACK;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = done;
                    if (done) begin
                        n_state = S_IDLE;
                    end else begin
                        n_step = step_next;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/clock_synth_divider_programmer.sv =====
// A status-only result goes from the request through the emit state into the output
// register; a set frequency request first runs the serial divider (30 + 20 + 7
// restoring steps, one multiply, loads and packing) before its first write.
// Throughput: one result per cycle while emitting and the output is not stalled; the next
// request is taken once the last result of the current one is in the output register.
// Reset: synchronous, active low; frequency 28074000, output off, device absent.
module clock_synth_divider_programmer import csdp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_frequency_hz,
    input  logic        i_enable,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_reg_address,
    output logic [7:0]  o_reg_data,
    output logic        o_is_write,
    output logic        o_error,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic     r_present;
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'b0, r_present} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            r_present <= pwdata[0];
        end
    end

    csdp_controller u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_frequency_hz (i_frequency_hz),
        .i_present      (r_present),
        .i_stat         (dp_stat),
        .o_cmd          (dp_cmd)
    );

    csdp_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_frequency_hz (i_frequency_hz),
        .i_enable       (i_enable),
        .o_stat         (dp_stat),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_reg_address  (o_reg_address),
        .o_reg_data     (o_reg_data),
        .o_is_write     (o_is_write),
        .o_error        (o_error),
        .o_last         (o_last)
    );

endmodule

// ===== design/csdp_checker.sv =====
module csdp_checker import csdp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_reg_address,
    input logic [7:0]  o_reg_data,
    input logic        o_is_write,
    input logic        o_error,
    input logic        o_last
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("reset did not clear output and return to idle");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_reg_address)
            && $stable(o_reg_data) && $stable(o_is_write) && $stable(o_error)
            && $stable(o_last))
        else $error("stalled result changed");

    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_write |-> o_last && o_reg_address == 8'd0
            && o_reg_data == 8'd0)
        else $error("status-only result malformed");

    a_pll_reset_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_write && o_reg_address == REG_PLL_RST |->
            o_reg_data == PLL_RST_VAL && !o_error)
        else $error("PLL reset write carries wrong data");

endmodule

bind clock_synth_divider_programmer csdp_checker u_checker (.*);

// ===== tb/sv/tb.sv =====
module tb;
    import csdp_pkg::*;

    localparam logic [1:0]  CMD_UNUSED          = 2'd3;
    localparam logic [2:0]  ADDR_DEVICE_PRESENT = 3'd0;
    localparam logic [31:0] REF_HZ              = 32'd900000000;
    localparam logic [31:0] DEN                 = 32'd1000000;
    localparam logic [31:0] PLL_FB_P1           = 32'd4096;
    localparam int          SETTLE_CYCLES       = 120;
    localparam int          HOLD_CYCLES         = 400;
    localparam int          CYCLE_LIMIT         = 600000;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] freq;
        logic        en;
    } t_synth_cmd;

    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] data;
        logic       is_write;
        logic       err;
        logic       last;
    } t_reg_write;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [1:0]  i_command      = 2'd0;
    logic [31:0] i_frequency_hz = 32'd0;
    logic        i_enable       = 1'b0;
    logic        i_ready        = 1'b0;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [2:0]  paddr          = 3'd0;
    logic [31:0] pwdata         = 32'd0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_reg_address;
    logic [7:0]  o_reg_data;
    logic        o_is_write;
    logic        o_error;
    logic        o_last;
    logic [31:0] prdata;
    logic        pready;

    t_synth_cmd  cmd_backlog[$];
    t_reg_write  due_writes[$];
    t_synth_cmd  next_cmd;
    t_reg_write  got_write;
    t_reg_write  want_write;

    logic [31:0] synth_freq   = 32'd28074000;
    logic        synth_oe     = 1'b0;
    logic        dev_present  = 1'b0;

    int          send_idle    = 0;
    int          recv_idle    = 0;
    bit          hold_request = 1'b0;
    int          hold_left    = 0;
    int          errors       = 0;
    int          cycle_count  = 0;

    clock_synth_divider_programmer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_frequency_hz (i_frequency_hz),
        .i_enable       (i_enable),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_reg_address  (o_reg_address),
        .o_reg_data     (o_reg_data),
        .o_is_write     (o_is_write),
        .o_error        (o_error),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_reg_write reg_write(input logic [7:0] addr, input logic [7:0] data,
                                             input logic err);
        return {addr, data, 1'b1, err, 1'b0};
    endfunction

    task automatic push_param_bytes(input logic [7:0] base, input logic [31:0] p1,
                                    input logic [31:0] p2, input logic [31:0] p3,
                                    input logic err);
        due_writes.push_back(reg_write(base + 8'd0, p3[15:8], err));
        due_writes.push_back(reg_write(base + 8'd1, p3[7:0], err));
        due_writes.push_back(reg_write(base + 8'd2, {6'b0, p1[17:16]}, err));
        due_writes.push_back(reg_write(base + 8'd3, p1[15:8], err));
        due_writes.push_back(reg_write(base + 8'd4, p1[7:0], err));
        due_writes.push_back(reg_write(base + 8'd5, {p3[19:16], p2[19:16]}, err));
        due_writes.push_back(reg_write(base + 8'd6, p2[15:8], err));
        due_writes.push_back(reg_write(base + 8'd7, p2[7:0], err));
    endtask

    // freq must be nonzero
    task automatic push_divider(input logic [31:0] freq);
        logic [31:0] whole;
        logic [31:0] rem;
        logic [63:0] wide;
        logic [31:0] frac;
        logic [31:0] frac128;
        logic [31:0] q;
        logic [31:0] p1;
        logic [31:0] p2;
        whole   = REF_HZ / freq;
        rem     = REF_HZ % freq;
        wide    = ({32'd0, rem} * {32'd0, DEN}) / {32'd0, freq};
        frac    = wide[31:0];
        frac128 = frac << 7;
        q       = frac128 / DEN;
        p1      = (whole << 7) + q - 32'd512;
        p2      = frac128 - DEN * q;
        push_param_bytes(DIV_BASE, p1, p2, DEN, 1'b0);
        due_writes.push_back(reg_write(REG_MS_CTRL, MS_CTRL_VAL, 1'b0));
        due_writes.push_back(reg_write(REG_PLL_RST, PLL_RST_VAL, 1'b0));
    endtask

    task automatic plan_command(input logic [1:0] cmd, input logic [31:0] freq,
                                input logic en);
        int         n0;
        logic       err;
        t_reg_write tail;
        n0 = due_writes.size();
        case (cmd)
            CMD_INIT: begin
                if (!dev_present) begin
                    due_writes.push_back({8'd0, 8'd0, 1'b0, 1'b0, 1'b1});
                end else begin
                    err = (synth_freq == 32'd0);
                    due_writes.push_back(reg_write(REG_OE, OE_OFF, err));
                    push_param_bytes(PLL_BASE, PLL_FB_P1, 32'd0, 32'd1, err);
                    if (!err) begin
                        push_divider(synth_freq);
                    end
                    if (synth_oe) begin
                        due_writes.push_back(reg_write(REG_OE, OE_ON, err));
                    end
                end
            end
            CMD_SET_FREQ: begin
                synth_freq = freq;
                if (freq == 32'd0) begin
                    due_writes.push_back({8'd0, 8'd0, 1'b0, 1'b1, 1'b1});
                end else if (!dev_present) begin
                    due_writes.push_back({8'd0, 8'd0, 1'b0, 1'b0, 1'b1});
                end else begin
                    push_divider(freq);
                end
            end
            CMD_SET_OE: begin
                synth_oe = en;
                if (!dev_present) begin
                    due_writes.push_back({8'd0, 8'd0, 1'b0, 1'b0, 1'b1});
                end else begin
                    due_writes.push_back(reg_write(REG_OE, en ? OE_ON : OE_OFF, 1'b0));
                end
            end
            default: begin
            end
        endcase
        if (due_writes.size() > n0) begin
            tail = due_writes.pop_back();
            tail.last = 1'b1;
            due_writes.push_back(tail);
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                plan_command(i_command, i_frequency_hz, i_enable);
            end
            if (!i_valid || o_ready) begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
                    next_cmd = cmd_backlog.pop_front();
                    i_valid        <= 1'b1;
                    i_command      <= next_cmd.command;
                    i_frequency_hz <= next_cmd.freq;
                    i_enable       <= next_cmd.en;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got_write = {o_reg_address, o_reg_data, o_is_write, o_error, o_last};
                if (due_writes.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result addr=%h data=%h wr=%b err=%b last=%b",
                             $time, o_reg_address, o_reg_data, o_is_write, o_error, o_last);
                end else begin
                    want_write = due_writes.pop_front();
                    if (got_write.addr !== want_write.addr ||
                        got_write.data !== want_write.data ||
                        got_write.is_write !== want_write.is_write ||
                        got_write.err !== want_write.err ||
                        got_write.last !== want_write.last) begin
                        errors++;
                        $display("%0t: mismatch expected addr=%h data=%h wr=%b err=%b last=%b",
                                 $time, want_write.addr, want_write.data,
                                 want_write.is_write, want_write.err, want_write.last);
                        $display("%0t:          actual   addr=%h data=%h wr=%b err=%b last=%b",
                                 $time, got_write.addr, got_write.data,
                                 got_write.is_write, got_write.err, got_write.last);
                    end
                end
            end
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic queue_cmd(input logic [1:0] cmd, input logic [31:0] freq,
                             input logic en);
        cmd_backlog.push_back({cmd, freq, en});
    endtask

    task automatic queue_random(input int count);
        int          placed;
        int          roll;
        logic [1:0]  cmd;
        logic [31:0] freq;
        placed = 0;
        while (placed < count) begin
            roll = $urandom_range(99);
            if (roll < 45) begin
                cmd = CMD_SET_FREQ;
            end else if (roll < 75) begin
                cmd = CMD_INIT;
            end else if (roll < 95) begin
                cmd = CMD_SET_OE;
            end else begin
                cmd = CMD_UNUSED;
            end
            roll = $urandom_range(99);
            if (roll < 4) begin
                freq = 32'd0;
            end else if (roll < 15) begin
                freq = $urandom_range(1, 1000);
            end else if (roll < 60) begin
                freq = $urandom_range(1000000, 200000000);
            end else if (roll < 75) begin
                freq = $urandom_range(850000000, 950000000);
            end else begin
                freq = $urandom();
            end
            queue_cmd(cmd, freq, 1'($urandom_range(1)));
            if (cmd != CMD_UNUSED) begin
                placed++;
            end
        end
    endtask

    task automatic drain();
        while (cmd_backlog.size() != 0 || i_valid || due_writes.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_DEVICE_PRESENT) begin
            dev_present = data[0];
        end
        @(negedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // device absent: state only, status results
        send_idle = 38;
        recv_idle = 67;
        queue_cmd(CMD_INIT, 32'd0, 1'b0);
        queue_cmd(CMD_SET_FREQ, 32'd0, 1'b1);
        queue_cmd(CMD_SET_FREQ, 32'd1000000, 1'b0);
        queue_cmd(CMD_SET_OE, 32'hFFFFFFFF, 1'b1);
        queue_cmd(CMD_UNUSED, 32'h5A5AA5A5, 1'b1);
        drain();

        apb_write(ADDR_DEVICE_PRESENT, 32'd1);
        queue_cmd(CMD_INIT, 32'd0, 1'b0);
        queue_cmd(CMD_SET_FREQ, 32'd0, 1'b0);
        queue_cmd(CMD_INIT, 32'hFFFFFFFF, 1'b1);
        queue_cmd(CMD_SET_OE, 32'd0, 1'b0);
        queue_cmd(CMD_INIT, 32'd0, 1'b0);
        queue_cmd(CMD_SET_FREQ, 32'd1, 1'b0);
        queue_cmd(CMD_SET_FREQ, 32'hFFFFFFFF, 1'b0);
        queue_cmd(CMD_SET_FREQ, 32'd900000000, 1'b0);
        queue_cmd(CMD_SET_FREQ, 32'd900000001, 1'b0);
        queue_cmd(CMD_SET_FREQ, 32'd899999999, 1'b0);
        queue_cmd(CMD_SET_FREQ, 32'd7, 1'b0);
        queue_cmd(CMD_SET_FREQ, 32'd28074000, 1'b0);
        queue_cmd(CMD_SET_OE, 32'd0, 1'b1);
        queue_cmd(CMD_UNUSED, 32'hFFFFFFFF, 1'b0);
        queue_cmd(CMD_SET_FREQ, 32'd10000000, 1'b0);
        queue_cmd(CMD_INIT, 32'd0, 1'b1);
        queue_cmd(CMD_SET_OE, 32'd0, 1'b0);
        drain();

        queue_random(130);
        drain();
        apb_write(ADDR_DEVICE_PRESENT, 32'd0);
        queue_random(50);
        drain();
        apb_write(ADDR_DEVICE_PRESENT, 32'd1);

        send_idle = 67;
        recv_idle = 38;
        queue_random(105);
        drain();

        send_idle = 0;
        recv_idle = 0;
        queue_random(105);
        repeat (20) @(negedge i_clk);
        hold_request = 1'b1;
        drain();

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/csdp_pkg.sv
design/csdp_datapath.sv
design/csdp_controller.sv
design/clock_synth_divider_programmer.sv
design/csdp_checker.sv
tb/sv/tb.sv
